### rtl/vfas_pkg.sv
// vfas_pkg: shared constants, codes and the result word type for the
// audio-master video frame sync unit. no dependencies.
package vfas_pkg;

	// default width of the pts, audio clock and now time fields in microseconds
	localparam int TIME_BITS_DEF = 52;

	// configuration register indexes
	localparam logic REG_AUDIO_PRESENT    = 1'b0;
	localparam logic REG_DISPLAY_ATTACHED = 1'b1;

	// input function codes
	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_FRAME = 1'b1;

	// result status codes
	localparam logic [2:0] ST_STARTED     = 3'd0;
	localparam logic [2:0] ST_NO_AUDIO    = 3'd1;
	localparam logic [2:0] ST_OUT_OF_SYNC = 3'd2;
	localparam logic [2:0] ST_LATE        = 3'd3;
	localparam logic [2:0] ST_ZERO_DELAY  = 3'd4;
	localparam logic [2:0] ST_SHOW        = 3'd5;

	// timing constants in microseconds
	localparam logic [19:0] DELAY_INIT_US = 20'd40000;
	localparam logic [19:0] DELAY_MAX_US  = 20'd1000000;
	localparam logic [19:0] SYNC_MIN_US   = 20'd10000;
	localparam logic [23:0] NOSYNC_US     = 24'd10000000;
	localparam logic [23:0] WAIT_ROUND_US = 24'd500;
	localparam logic [23:0] WAIT_SAT_US   = 24'd4000000;

	typedef struct packed {
		logic [2:0]  status;
		logic        show_frame;
		logic [21:0] wait_us;
	} result_t;

endpackage

### rtl/vfas_in_stage.sv
// vfas_in_stage: input register of the frame sync unit, holds one word
// until the timing stage consumes it. depends on vfas_pkg.
module vfas_in_stage #(
	parameter int TIME_BITS = vfas_pkg::TIME_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 func,
	input  logic [TIME_BITS-1:0] pts_us,
	input  logic [TIME_BITS-1:0] audio_clock_us,
	input  logic [TIME_BITS-1:0] now_us,
	input  logic                 advance,
	output logic                 valid_s1,
	output logic                 func_s1,
	output logic [TIME_BITS-1:0] pts_s1,
	output logic [TIME_BITS-1:0] aud_s1,
	output logic [TIME_BITS-1:0] now_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_s1 <= func;
			pts_s1  <= pts_us;
			aud_s1  <= audio_clock_us;
			now_s1  <= now_us;
		end
	end

endmodule

### rtl/vfas_timing.sv
// vfas_timing: sync state (last pts, last delay, frame timer), configuration
// registers and the single-pass delay/late/wait logic. depends on vfas_pkg.
module vfas_timing #(
	parameter int TIME_BITS = vfas_pkg::TIME_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic                 cfg_index,
	input  logic                 cfg_data,
	input  logic                 advance,
	input  logic                 func_s1,
	input  logic [TIME_BITS-1:0] pts_s1,
	input  logic [TIME_BITS-1:0] aud_s1,
	input  logic [TIME_BITS-1:0] now_s1,
	output vfas_pkg::result_t    result
);

	logic                 audio_present_q;
	logic                 display_attached_q;
	logic [TIME_BITS-1:0] last_pts_q;
	logic [19:0]          last_delay_q;
	logic [TIME_BITS-1:0] frame_time_q;

	logic [TIME_BITS-1:0] step;
	logic                 step_ok;
	logic [19:0]          delay0;
	logic                 video_ahead;
	logic [TIME_BITS-1:0] gap;
	logic [19:0]          thr;
	logic                 no_sync;
	logic [20:0]          delay1;
	logic                 ft_ge;
	logic [TIME_BITS-1:0] behind;
	logic [TIME_BITS-1:0] ahead;
	logic                 late;
	logic [23:0]          wait_raw;
	logic [21:0]          wait_sat;
	logic                 update_ft;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			audio_present_q    <= 1'b0;
			display_attached_q <= 1'b0;
		end else if (cfg_wr_en) begin
			if (cfg_index == vfas_pkg::REG_AUDIO_PRESENT) begin
				audio_present_q <= cfg_data;
			end else begin
				display_attached_q <= cfg_data;
			end
		end
	end

	always_comb begin
		step    = pts_s1 - last_pts_q;
		step_ok = (pts_s1 > last_pts_q) && (step < TIME_BITS'(vfas_pkg::DELAY_MAX_US));
		delay0  = step_ok ? step[19:0] : last_delay_q;

		video_ahead = pts_s1 >= aud_s1;
		gap     = video_ahead ? (pts_s1 - aud_s1) : (aud_s1 - pts_s1);
		thr     = (delay0 > vfas_pkg::SYNC_MIN_US) ? delay0 : vfas_pkg::SYNC_MIN_US;
		no_sync = gap >= TIME_BITS'(vfas_pkg::NOSYNC_US);

		// once the gap reaches the threshold, audio ahead drops the delay, video ahead doubles it
		if (gap >= TIME_BITS'(thr)) begin
			delay1 = video_ahead ? {delay0, 1'b0} : 21'd0;
		end else begin
			delay1 = {1'b0, delay0};
		end

		ft_ge  = frame_time_q >= now_s1;
		behind = now_s1 - frame_time_q;
		ahead  = frame_time_q - now_s1;
		late   = !ft_ge && (behind > TIME_BITS'(delay1));

		if (ft_ge) begin
			if (ahead > TIME_BITS'(vfas_pkg::WAIT_SAT_US)) begin
				wait_raw = vfas_pkg::WAIT_SAT_US;
			end else begin
				wait_raw = 24'(ahead[21:0]) + 24'(delay1) + vfas_pkg::WAIT_ROUND_US;
			end
		end else if (!late) begin
			// behind fits in the delay width here
			wait_raw = 24'(delay1) - 24'(behind[20:0]) + vfas_pkg::WAIT_ROUND_US;
		end else begin
			wait_raw = 24'd0;
		end
		wait_sat = (wait_raw > vfas_pkg::WAIT_SAT_US) ? vfas_pkg::WAIT_SAT_US[21:0]
			: wait_raw[21:0];

		update_ft = 1'b0;
		result.show_frame = 1'b0;
		result.wait_us    = 22'd0;
		if (func_s1 == vfas_pkg::FUNC_START) begin
			result.status = vfas_pkg::ST_STARTED;
		end else if (!audio_present_q) begin
			result.status = vfas_pkg::ST_NO_AUDIO;
		end else if (no_sync) begin
			result.status = vfas_pkg::ST_OUT_OF_SYNC;
		end else begin
			update_ft = 1'b1;
			if (late) begin
				result.status = vfas_pkg::ST_LATE;
			end else if (delay1 == 21'd0) begin
				result.status = vfas_pkg::ST_ZERO_DELAY;
			end else begin
				result.status     = vfas_pkg::ST_SHOW;
				result.show_frame = display_attached_q;
				result.wait_us    = wait_sat;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pts_q   <= '0;
			last_delay_q <= vfas_pkg::DELAY_INIT_US;
			frame_time_q <= '0;
		end else if (advance) begin
			if (func_s1 == vfas_pkg::FUNC_START) begin
				last_pts_q   <= '0;
				last_delay_q <= vfas_pkg::DELAY_INIT_US;
				frame_time_q <= now_s1;
			end else begin
				last_pts_q   <= pts_s1;
				last_delay_q <= delay0;
				if (update_ft) begin
					frame_time_q <= frame_time_q + TIME_BITS'(delay1);
				end
			end
		end
	end

endmodule

### rtl/vfas_out_stage.sv
// vfas_out_stage: result register of the frame sync unit with its valid/ready
// side. depends on vfas_pkg.
module vfas_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load_valid,
	output logic              load_ready,
	input  vfas_pkg::result_t result,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        status,
	output logic              show_frame,
	output logic [21:0]       wait_us
);

	logic              valid_s2;
	vfas_pkg::result_t result_s2;

	assign load_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_ready) begin
			valid_s2 <= load_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_valid && load_ready) begin
			result_s2 <= result;
		end
	end

	assign out_valid  = valid_s2;
	assign status     = result_s2.status;
	assign show_frame = result_s2.show_frame;
	assign wait_us    = result_s2.wait_us;

endmodule

### rtl/video_frame_av_sync_unit.sv
// video_frame_av_sync_unit: top level of the audio-master video frame sync.
// depends on vfas_pkg, vfas_in_stage, vfas_timing, vfas_out_stage.
//
//   channel  handshake            payload
//   in       in_valid/in_ready    func, pts_us, audio_clock_us, now_us
//   out      out_valid/out_ready  status, show_frame, wait_us
//   cfg      cfg_wr_en            cfg_index, cfg_data
//
// one word per cycle sustained while out_ready is high; a word passes through
// the input register, then the timing logic into the result register.
// sync state is written as a word leaves the input register, so the next
// word sees it. reset restores 40 ms delay, zero pts and zero frame timer.
// a stalled result holds and one more word may wait in the input register.
module video_frame_av_sync_unit #(
	parameter int TIME_BITS = vfas_pkg::TIME_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic                 cfg_index,
	input  logic                 cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 func,
	input  logic [TIME_BITS-1:0] pts_us,
	input  logic [TIME_BITS-1:0] audio_clock_us,
	input  logic [TIME_BITS-1:0] now_us,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [2:0]           status,
	output logic                 show_frame,
	output logic [21:0]          wait_us
);

	logic                 valid_s1;
	logic                 func_s1;
	logic [TIME_BITS-1:0] pts_s1;
	logic [TIME_BITS-1:0] aud_s1;
	logic [TIME_BITS-1:0] now_s1;
	logic                 load_ready;
	logic                 advance;
	vfas_pkg::result_t    result;

	assign advance = valid_s1 && load_ready;

	vfas_in_stage #(
		.TIME_BITS (TIME_BITS)
	) u_in (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.pts_us         (pts_us),
		.audio_clock_us (audio_clock_us),
		.now_us         (now_us),
		.advance        (advance),
		.valid_s1       (valid_s1),
		.func_s1        (func_s1),
		.pts_s1         (pts_s1),
		.aud_s1         (aud_s1),
		.now_s1         (now_s1)
	);

	vfas_timing #(
		.TIME_BITS (TIME_BITS)
	) u_timing (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.advance   (advance),
		.func_s1   (func_s1),
		.pts_s1    (pts_s1),
		.aud_s1    (aud_s1),
		.now_s1    (now_s1),
		.result    (result)
	);

	vfas_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s1),
		.load_ready (load_ready),
		.result     (result),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.show_frame (show_frame),
		.wait_us    (wait_us)
	);

endmodule

### rtl/vfas_checker.sv
// vfas_checker: port-level assertions for the frame sync unit, bound to the
// top level. depends on vfas_pkg and video_frame_av_sync_unit.
module vfas_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  status,
	input logic        show_frame,
	input logic [21:0] wait_us
);

	// a held result keeps its word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(show_frame)
			&& $stable(wait_us))
		else $error("result changed while stalled");

	// only a shown frame carries a wait or reaches the display
	a_non_show_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != vfas_pkg::ST_SHOW |-> !show_frame && wait_us == 22'd0)
		else $error("non-show result with wait or display flag");

	// a shown frame always waits at least the rounding margin, at most saturation
	a_show_wait: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == vfas_pkg::ST_SHOW |->
			wait_us >= 22'd500 && wait_us <= 22'd4000000)
		else $error("show wait out of range");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= vfas_pkg::ST_SHOW)
		else $error("status code beyond show");

endmodule

bind video_frame_av_sync_unit vfas_checker u_vfas_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.status     (status),
	.show_frame (show_frame),
	.wait_us    (wait_us)
);

### sim/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for video_frame_av_sync_unit, with directed frame
// timing cases and then random frame streams. depends on vfas_pkg and the rtl top.
module tb_top;

	localparam int TB = vfas_pkg::TIME_BITS_DEF;

	logic          clk;
	logic          arst_n;
	logic          cfg_wr_en;
	logic          cfg_index;
	logic          cfg_data;
	logic          in_valid;
	logic          in_ready;
	logic          func;
	logic [TB-1:0] pts_us;
	logic [TB-1:0] audio_clock_us;
	logic [TB-1:0] now_us;
	logic          out_valid;
	logic          out_ready;
	logic [2:0]    status;
	logic          show_frame;
	logic [21:0]   wait_us;

	// sync state as the block should hold it
	logic [TB-1:0] prev_pts;
	logic [19:0]   prev_delay;
	logic [TB-1:0] ft_model;
	logic          audio_on;
	logic          display_on;

	vfas_pkg::result_t pending_results[$];
	vfas_pkg::result_t want_result;
	int            err_cnt;
	logic          idle_on;
	logic [TB-1:0] s_pts;

	video_frame_av_sync_unit u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.pts_us         (pts_us),
		.audio_clock_us (audio_clock_us),
		.now_us         (now_us),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.show_frame     (show_frame),
		.wait_us        (wait_us)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [TB-1:0] rand_time();
		logic [63:0] v;
		v = {$urandom(), $urandom()};
		return v[TB-1:0];
	endfunction

	// frame delay that a frame with this pts would pick up
	function automatic logic [63:0] next_delay(logic [TB-1:0] pts);
		if (pts > prev_pts && pts - prev_pts < vfas_pkg::DELAY_MAX_US)
			return 64'(pts - prev_pts);
		return 64'(prev_delay);
	endfunction

	function automatic vfas_pkg::result_t compute_sync_result(logic fn, logic [TB-1:0] pts,
			logic [TB-1:0] aud, logic [TB-1:0] now);
		logic [63:0] dly;
		logic [63:0] thr;
		logic [63:0] gap;
		logic [63:0] ahead;
		logic [63:0] hold;
		logic        fwd;
		logic        late;
		vfas_pkg::result_t r;
		r = '0;
		if (fn == vfas_pkg::FUNC_START) begin
			ft_model = now;
			prev_delay = vfas_pkg::DELAY_INIT_US;
			prev_pts = '0;
			r.status = vfas_pkg::ST_STARTED;
			return r;
		end
		dly = next_delay(pts);
		prev_delay = dly[19:0];
		prev_pts = pts;
		if (!audio_on) begin
			r.status = vfas_pkg::ST_NO_AUDIO;
			return r;
		end
		fwd = pts >= aud;
		gap = fwd ? 64'(pts - aud) : 64'(aud - pts);
		thr = (dly > vfas_pkg::SYNC_MIN_US) ? dly : 64'(vfas_pkg::SYNC_MIN_US);
		if (gap >= vfas_pkg::NOSYNC_US) begin
			r.status = vfas_pkg::ST_OUT_OF_SYNC;
			return r;
		end
		if (gap >= thr)
			dly = fwd ? 2 * dly : 64'd0;
		// late means ft_model + delay < now, exact
		if (ft_model >= now)
			late = 1'b0;
		else
			late = 64'(now - ft_model) > dly;
		if (ft_model >= now) begin
			ahead = 64'(ft_model - now);
			hold = (ahead > vfas_pkg::WAIT_SAT_US) ? 64'(vfas_pkg::WAIT_SAT_US)
				: ahead + dly + 64'(vfas_pkg::WAIT_ROUND_US);
		end else if (!late) begin
			hold = dly - 64'(now - ft_model) + 64'(vfas_pkg::WAIT_ROUND_US);
		end else begin
			hold = 64'd0;
		end
		if (hold > vfas_pkg::WAIT_SAT_US)
			hold = 64'(vfas_pkg::WAIT_SAT_US);
		ft_model = ft_model + dly[TB-1:0];
		if (late)
			r.status = vfas_pkg::ST_LATE;
		else if (dly == 0)
			r.status = vfas_pkg::ST_ZERO_DELAY;
		else begin
			r.status = vfas_pkg::ST_SHOW;
			r.show_frame = display_on;
			r.wait_us = hold[21:0];
		end
		return r;
	endfunction

	task automatic report_mismatch(string what);
		$display("%0t: %s", $time, what);
		err_cnt++;
	endtask

	// result check, word moves at the next rising edge
	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result word with nothing pending");
			end else begin
				want_result = pending_results.pop_front();
				if (status !== want_result.status)
					report_mismatch($sformatf("status %0d, want %0d", status,
						want_result.status));
				if (show_frame !== want_result.show_frame)
					report_mismatch($sformatf("show_frame %0d, want %0d", show_frame,
						want_result.show_frame));
				if (wait_us !== want_result.wait_us)
					report_mismatch($sformatf("wait_us %0d, want %0d", wait_us,
						want_result.wait_us));
			end
		end
	end

	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	task automatic send_word(logic fn, logic [TB-1:0] pts, logic [TB-1:0] aud,
			logic [TB-1:0] now);
		logic rdy;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= fn;
		pts_us <= pts;
		audio_clock_us <= aud;
		now_us <= now;
		do begin
			@(negedge clk);
			rdy = in_ready;
			@(posedge clk);
		end while (!rdy);
		pending_results.push_back(compute_sync_result(fn, pts, aud, now));
	endtask

	task automatic wait_idle();
		int n;
		n = 0;
		in_valid <= 1'b0;
		while (pending_results.size() != 0 && n < 20000) begin
			@(posedge clk);
			n++;
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == vfas_pkg::REG_AUDIO_PRESENT)
			audio_on = val;
		else
			display_on = val;
		@(posedge clk);
	endtask

	// one frame of a plausible stream: pts steps, audio near video, now near the timer
	task automatic send_stream_frame();
		logic [TB-1:0] pts;
		logic [TB-1:0] aud;
		logic [TB-1:0] now;
		logic [63:0]   dly;
		logic [63:0]   thr;
		logic [63:0]   mag;
		int            k;
		k = $urandom_range(0, 19);
		if (k == 0)
			pts = s_pts;
		else if (k == 1)
			pts = s_pts - $urandom_range(1, 2000000);
		else if (k == 2)
			pts = s_pts + vfas_pkg::DELAY_MAX_US + $urandom_range(0, 50000000);
		else if (k == 3)
			pts = s_pts + vfas_pkg::DELAY_MAX_US - 1;
		else if (k == 4)
			pts = s_pts + vfas_pkg::DELAY_MAX_US;
		else
			pts = s_pts + $urandom_range(1, 80000);
		s_pts = pts;
		dly = next_delay(pts);
		thr = (dly > vfas_pkg::SYNC_MIN_US) ? dly : 64'(vfas_pkg::SYNC_MIN_US);
		case ($urandom_range(0, 9))
			0: mag = thr;
			1: mag = thr - 1;
			2: mag = 64'(vfas_pkg::NOSYNC_US);
			3: mag = 64'(vfas_pkg::NOSYNC_US) - 1;
			4: mag = $urandom_range(0, 30000000);
			default: mag = $urandom_range(0, thr[31:0] + thr[31:0] / 2);
		endcase
		aud = $urandom_range(0, 1) ? TB'(pts + mag) : TB'(pts - mag);
		case ($urandom_range(0, 9))
			0: now = TB'(ft_model + dly + 1 + $urandom_range(0, 100000));
			1: now = TB'(ft_model + dly);
			2: now = TB'(ft_model - (vfas_pkg::WAIT_SAT_US - vfas_pkg::WAIT_ROUND_US - dly)
				+ $urandom_range(0, 2) - 1);
			3: now = ft_model - vfas_pkg::WAIT_SAT_US - $urandom_range(0, 1);
			4: now = ft_model - $urandom_range(0, 8000000);
			default: now = ft_model + $urandom_range(0, dly[31:0]);
		endcase
		send_word(vfas_pkg::FUNC_FRAME, pts, aud, now);
	endtask

	task automatic test_reset_state();
		// audio is off out of reset, history still updates
		send_word(vfas_pkg::FUNC_FRAME, '0, '0, '0);
		wait_idle();
		write_reg(vfas_pkg::REG_AUDIO_PRESENT, 1'b1);
		write_reg(vfas_pkg::REG_DISPLAY_ATTACHED, 1'b1);
	endtask

	task automatic test_delay_select();
		logic [TB-1:0] p;
		send_word(vfas_pkg::FUNC_START, rand_time(), rand_time(), 52'd1000);
		p = '0;
		send_word(vfas_pkg::FUNC_FRAME, p, p, ft_model);
		p = p + 40000;
		send_word(vfas_pkg::FUNC_FRAME, p, p, ft_model);
		p = p + vfas_pkg::DELAY_MAX_US - 1;
		send_word(vfas_pkg::FUNC_FRAME, p, p, ft_model);
		p = p + vfas_pkg::DELAY_MAX_US;
		send_word(vfas_pkg::FUNC_FRAME, p, p, ft_model);
		p = p - 5;
		send_word(vfas_pkg::FUNC_FRAME, p, p, ft_model);
	endtask

	task automatic test_sync_window();
		logic [TB-1:0] p;
		send_word(vfas_pkg::FUNC_START, '0, '0, '0);
		p = 33333;
		send_word(vfas_pkg::FUNC_FRAME, p, p - 33333, ft_model);
		p = p + 33333;
		send_word(vfas_pkg::FUNC_FRAME, p, p + 33333, ft_model);
		p = p + 33333;
		send_word(vfas_pkg::FUNC_FRAME, p, p + 33332, ft_model);
		p = p + 33333;
		send_word(vfas_pkg::FUNC_FRAME, p, p - (vfas_pkg::NOSYNC_US - 1), ft_model);
		p = p + 33333;
		send_word(vfas_pkg::FUNC_FRAME, p, p - vfas_pkg::NOSYNC_US, ft_model);
		p = p + 33333;
		send_word(vfas_pkg::FUNC_FRAME, p, p + vfas_pkg::NOSYNC_US, ft_model);
		// short step, threshold held at its floor
		p = p + 5000;
		send_word(vfas_pkg::FUNC_FRAME, p, p - 9999, ft_model);
	endtask

	task automatic test_late_and_wait();
		logic [TB-1:0] p;
		p = s_pts + 100000000;
		send_word(vfas_pkg::FUNC_START, '0, '0, 52'd7);
		send_word(vfas_pkg::FUNC_FRAME, p, p, ft_model + 40000);
		send_word(vfas_pkg::FUNC_FRAME, p, p, ft_model + 40001);
		send_word(vfas_pkg::FUNC_FRAME, p, p, ft_model - vfas_pkg::WAIT_SAT_US - 1);
		send_word(vfas_pkg::FUNC_FRAME, p, p, ft_model - (vfas_pkg::WAIT_SAT_US - 40500));
		send_word(vfas_pkg::FUNC_FRAME, p, p, ft_model - vfas_pkg::WAIT_SAT_US);
	endtask

	task automatic test_time_wrap();
		send_word(vfas_pkg::FUNC_START, '1, '1, '1);
		send_word(vfas_pkg::FUNC_FRAME, '1, '1, '1);
		send_word(vfas_pkg::FUNC_FRAME, '0, '0, '0);
		send_word(vfas_pkg::FUNC_FRAME, '1, '0, '1);
	endtask

	task automatic test_display_off();
		wait_idle();
		write_reg(vfas_pkg::REG_DISPLAY_ATTACHED, 1'b0);
		send_word(vfas_pkg::FUNC_START, '0, '0, 52'd500);
		send_word(vfas_pkg::FUNC_FRAME, 52'd40000, 52'd40000, ft_model);
	endtask

	task automatic test_no_audio();
		wait_idle();
		write_reg(vfas_pkg::REG_AUDIO_PRESENT, 1'b0);
		send_word(vfas_pkg::FUNC_FRAME, 52'd80000, 52'd0, 52'd0);
	endtask

	task automatic test_random_phase(int n, logic ap, logic da, logic calm);
		int r;
		wait_idle();
		write_reg(vfas_pkg::REG_AUDIO_PRESENT, ap);
		write_reg(vfas_pkg::REG_DISPLAY_ATTACHED, da);
		idle_on = !calm;
		for (int i = 0; i < n; i++) begin
			if (!calm && i % 50 == 0)
				idle_on = ($urandom_range(0, 3) != 0);
			r = $urandom_range(0, 99);
			if (r < 4) begin
				s_pts = $urandom_range(0, 1) ? rand_time() : TB'($urandom_range(0, 1000000));
				send_word(vfas_pkg::FUNC_START, rand_time(), rand_time(),
					$urandom_range(0, 1) ? rand_time() : TB'($urandom()));
			end else if (r < 16) begin
				send_word(1'($urandom_range(0, 1)), rand_time(), rand_time(), rand_time());
			end else begin
				send_stream_frame();
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = 1'b0;
		cfg_data = 1'b0;
		in_valid = 1'b0;
		func = 1'b0;
		pts_us = '0;
		audio_clock_us = '0;
		now_us = '0;
		prev_pts = '0;
		prev_delay = vfas_pkg::DELAY_INIT_US;
		ft_model = '0;
		audio_on = 1'b0;
		display_on = 1'b0;
		err_cnt = 0;
		idle_on = 1'b1;
		s_pts = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_delay_select();
		test_sync_window();
		test_late_and_wait();
		test_time_wrap();
		test_display_off();
		test_no_audio();
		test_random_phase(200, 1'b1, 1'b1, 1'b0);
		test_random_phase(200, 1'b1, 1'b0, 1'b0);
		test_random_phase(60, 1'b0, 1'b1, 1'b0);
		test_random_phase(300, 1'b1, 1'b1, 1'b0);
		test_random_phase(150, 1'b1, 1'b1, 1'b1);

		wait_idle();
		if (pending_results.size() != 0)
			report_mismatch($sformatf("%0d result words never arrived",
				pending_results.size()));
		if (err_cnt == 0)
			$display("[video_frame_av_sync_unit] OK");
		else
			$display("[video_frame_av_sync_unit] ERROR");
		$finish;
	end

	initial begin
		#5000000;
		$display("[video_frame_av_sync_unit] ERROR");
		$finish;
	end

endmodule
